>>> hw/rtl/ray_convex_plane_clip_assert.svh
// Assertion macros for the port-level checker.
// Depends on nothing; included by rcpc_checker.sv.
`ifndef RAY_CONVEX_PLANE_CLIP_ASSERT_SVH
`define RAY_CONVEX_PLANE_CLIP_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define RCPC_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rcpc check failed");
// next-cycle implication
`define RCPC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rcpc check failed");
`endif

>>> hw/rtl/rcpc_pkg.sv
// Package for the ray convex plane clip block: types, register codes, sizes.
// No dependencies; used by the rcpc design modules and the testbench.
`default_nettype none
package rcpc_pkg;
  localparam int unsigned DataW = 32;
  localparam int unsigned DotW  = 66;

  typedef enum logic [2:0] {
    REG_START_X = 3'd0, REG_START_Y = 3'd1, REG_START_Z = 3'd2,
    REG_DIR_X   = 3'd3, REG_DIR_Y   = 3'd4, REG_DIR_Z   = 3'd5,
    REG_NEAR    = 3'd6, REG_FAR     = 3'd7
  } reg_idx_e;

  typedef enum logic [2:0] {
    FE_IDLE, FE_MUL, FE_SUM, FE_PUSH
  } fe_state_e;

  typedef enum logic [1:0] {
    BE_IDLE, BE_DIV, BE_UPD, BE_OUT
  } be_state_e;

  // classified plane handed from front to back
  typedef struct packed {
    logic              first;
    logic              last;
    logic              parallel;
    logic              in_front;
    logic signed [DotW-1:0] num;
    logic signed [DotW-1:0] den;
  } plane_t;
endpackage
`default_nettype wire

>>> hw/rtl/rcpc_front.sv
// Front end: accept a plane, form both dot products one normal component at a time.
// Depends on rcpc_pkg.
`default_nettype none
module rcpc_front #(
  parameter int unsigned FracBits = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [32*6-1:0]      cfg_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [129:0]         in_data_i,
  output logic                      push_o,
  output rcpc_pkg::plane_t          plane_o,
  input  wire logic                 full_i
);
  rcpc_pkg::fe_state_e state_q, state_d;
  logic [1:0] k_q, k_d;
  logic signed [31:0] n_q [3];
  logic signed [31:0] d_q;
  logic first_q, last_q;
  logic signed [63:0] pa_q, pp_q;
  logic signed [rcpc_pkg::DotW-1:0] sa_q, sp_q, la_q, lp_q;
  logic signed [rcpc_pkg::DotW-1:0] a_v, p_v, dd;
  logic signed [31:0] nsel, ssel, dsel;

  always_comb begin
    nsel = n_q[k_q];
    ssel = cfg_i[32*k_q +: 32];
    dsel = cfg_i[32*(32'(k_q)+3) +: 32];
  end

  // floor(sum)>>F is exact; low parts kept in la/lp
  always_comb begin
    a_v = sa_q + (la_q >>> FracBits);
    p_v = sp_q + (lp_q >>> FracBits);
    dd  = {{(rcpc_pkg::DotW-32){d_q[31]}}, d_q};
    plane_o.first    = first_q;
    plane_o.last     = last_q;
    plane_o.parallel = (a_v == '0);
    plane_o.in_front = (p_v > dd);
    plane_o.num      = dd - p_v;
    plane_o.den      = a_v;
  end

  always_comb begin
    state_d = state_q;
    k_d = k_q;
    in_ready_o = 1'b0;
    push_o = 1'b0;
    unique case (state_q)
      rcpc_pkg::FE_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = rcpc_pkg::FE_MUL;
          k_d = 2'd0;
        end
      end
      rcpc_pkg::FE_MUL: state_d = rcpc_pkg::FE_SUM;
      rcpc_pkg::FE_SUM: begin
        if (k_q == 2'd2) state_d = rcpc_pkg::FE_PUSH;
        else begin
          k_d = k_q + 2'd1;
          state_d = rcpc_pkg::FE_MUL;
        end
      end
      rcpc_pkg::FE_PUSH: begin
        if (!full_i) begin
          push_o = 1'b1;
          state_d = rcpc_pkg::FE_IDLE;
        end
      end
      default: state_d = rcpc_pkg::FE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rcpc_pkg::FE_IDLE;
      k_q <= '0;
    end else begin
      state_q <= state_d;
      k_q <= k_d;
    end
  end

  localparam logic [63:0] LoMask = (64'd1 << FracBits) - 64'd1;

  always_ff @(posedge clk_i) begin
    if (state_q == rcpc_pkg::FE_IDLE && in_valid_i) begin
      n_q[0] <= in_data_i[31:0];
      n_q[1] <= in_data_i[63:32];
      n_q[2] <= in_data_i[95:64];
      d_q <= in_data_i[127:96];
      first_q <= in_data_i[128];
      last_q <= in_data_i[129];
      sa_q <= '0; sp_q <= '0; la_q <= '0; lp_q <= '0;
    end
    if (state_q == rcpc_pkg::FE_MUL) begin
      pa_q <= dsel * nsel;
      pp_q <= ssel * nsel;
    end
    if (state_q == rcpc_pkg::FE_SUM) begin
      sa_q <= sa_q + rcpc_pkg::DotW'(pa_q >>> FracBits);
      sp_q <= sp_q + rcpc_pkg::DotW'(pp_q >>> FracBits);
      la_q <= la_q + rcpc_pkg::DotW'(pa_q & LoMask);
      lp_q <= lp_q + rcpc_pkg::DotW'(pp_q & LoMask);
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/rcpc_queue.sv
// Two-entry queue between front and back ends.
// Depends on rcpc_pkg.
`default_nettype none
module rcpc_queue (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  rcpc_pkg::plane_t  data_i,
  output logic              full_o,
  input  wire logic         pop_i,
  output logic              empty_o,
  output rcpc_pkg::plane_t  data_o
);
  rcpc_pkg::plane_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/rcpc_back.sv
// Back end: shared restoring divider, bound update and result register.
// Depends on rcpc_pkg.
`default_nettype none
module rcpc_back #(
  parameter int unsigned FracBits = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [31:0]        near_start_i,
  input  wire logic [31:0]        far_start_i,
  input  wire logic               empty_i,
  input  rcpc_pkg::plane_t        plane_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [66:0]             out_data_o
);
  localparam int unsigned QW = 66 + FracBits;
  localparam int unsigned CW = $clog2(QW + 1);

  rcpc_pkg::be_state_e state_q, state_d;
  logic [CW-1:0] cnt_q;
  logic [QW-1:0] n_q, q_q;
  logic [65:0] m_q, r_q;
  logic neg_q;
  rcpc_pkg::plane_t p_q;
  logic signed [31:0] near_q, far_q, t;
  logic ent_q, live_q, lst_q;
  logic [66:0] r_sh, r_sub;
  logic [QW-1:0] qsat;

  // one quotient bit per cycle
  always_comb begin
    r_sh  = {r_q, n_q[QW-1]};
    r_sub = r_sh - {1'b0, m_q};
  end

  always_comb begin
    qsat = q_q;
    if (neg_q) begin
      if (qsat > QW'(64'h80000000)) qsat = QW'(64'h80000000);
      t = 32'(-qsat);
    end else begin
      if (qsat > QW'(64'h7fffffff)) qsat = QW'(64'h7fffffff);
      t = 32'(qsat);
    end
  end

  always_comb begin
    state_d = state_q;
    pop_o = 1'b0;
    unique case (state_q)
      rcpc_pkg::BE_IDLE: if (!empty_i) begin
        pop_o = 1'b1;
        state_d = rcpc_pkg::BE_DIV;
      end
      rcpc_pkg::BE_DIV: if (cnt_q == '0) state_d = rcpc_pkg::BE_UPD;
      rcpc_pkg::BE_UPD: state_d = rcpc_pkg::BE_OUT;
      rcpc_pkg::BE_OUT: if (out_ready_i) state_d = rcpc_pkg::BE_IDLE;
      default: state_d = rcpc_pkg::BE_IDLE;
    endcase
  end

  assign out_valid_o = (state_q == rcpc_pkg::BE_OUT);
  assign out_data_o  = {lst_q, ent_q, far_q, near_q, live_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rcpc_pkg::BE_IDLE;
      near_q <= '0; far_q <= '0; ent_q <= 1'b0; live_q <= 1'b1;
    end else begin
      state_q <= state_d;
      if (state_q == rcpc_pkg::BE_UPD) begin
        logic nl;
        logic signed [31:0] nn, nf;
        logic ne;
        nl = live_q; nn = near_q; nf = far_q; ne = ent_q;
        if (p_q.first) begin
          nl = 1'b1; nn = near_start_i; nf = far_start_i; ne = 1'b0;
        end
        if (nl) begin
          if (p_q.parallel) begin
            if (p_q.in_front) nl = 1'b0;
          end else if (p_q.in_front && t < 0) begin
            nl = 1'b0;
          end else if (p_q.in_front || t < 0) begin
            if (nn < t) begin nn = t; ne = 1'b1; end
          end else if (t < nf) begin
            nf = t;
          end
        end
        live_q <= nl; near_q <= nn; far_q <= nf; ent_q <= ne;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      p_q <= plane_i;
      neg_q <= plane_i.num[65] ^ plane_i.den[65];
      n_q <= {(plane_i.num[65] ? 66'(-plane_i.num) : plane_i.num),
              {FracBits{1'b0}}};
      m_q <= plane_i.den[65] ? 66'(-plane_i.den) : plane_i.den;
      r_q <= '0; q_q <= '0;
      cnt_q <= CW'(QW);
    end else if (state_q == rcpc_pkg::BE_DIV && cnt_q != '0) begin
      n_q <= n_q << 1;
      if (!r_sub[66]) begin
        r_q <= r_sub[65:0]; q_q <= {q_q[QW-2:0], 1'b1};
      end else begin
        r_q <= r_sh[65:0]; q_q <= {q_q[QW-2:0], 1'b0};
      end
      cnt_q <= cnt_q - CW'(1);
    end
    if (state_q == rcpc_pkg::BE_UPD) lst_q <= p_q.last;
  end
endmodule
`default_nettype wire

>>> hw/rtl/ray_convex_plane_clip.sv
// Top level of the ray convex plane clip block.
// Depends on rcpc_pkg, rcpc_front, rcpc_queue, rcpc_back.
`default_nettype none
// Clips one ray against a convex solid, one bounding plane per input word.
// A front end takes the plane and builds start.n and dir.n with two 32x32
// multipliers, each shared over x/y/z, then queues the classified plane in a
// two-entry queue. A back end runs a restoring divider, one quotient bit a
// cycle over 66+FRAC_BITS bits (82 bits at Q16.16), updates entry/exit
// bounds and holds the result word until taken. The divider sets the rate;
// the front end overlaps the next plane.
// Registers (APB, byte address 4*i): start x/y/z, dir x/y/z, near start,
// far start. Write them only while idle.
module ray_convex_plane_clip #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [4:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  // normal_x, normal_y, normal_z, plane_offset
  input  wire logic [127:0]  s_axis_tdata,
  // first_plane
  input  wire logic          s_axis_tuser,
  input  wire logic          s_axis_tlast,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // hit_possible, near_out, far_out, use_normal_out, zero fill
  output logic [71:0]        m_axis_tdata,
  output logic               m_axis_tlast
);
  logic [31:0] cfg_q [8];
  logic [2:0] ridx;
  logic [32*6-1:0] cfg_flat;
  logic push, full, pop, empty;
  rcpc_pkg::plane_t qin, qout;
  logic [66:0] res;

  assign pready = 1'b1;
  assign ridx = paddr[4:2];
  assign prdata = cfg_q[ridx];

  // hold register file; written on the APB access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) cfg_q[i] <= '0;
      cfg_q[rcpc_pkg::REG_NEAR] <= 32'h80000000;
      cfg_q[rcpc_pkg::REG_FAR]  <= 32'h7fffffff;
    end else if (psel && penable && pwrite) begin
      cfg_q[ridx] <= pwdata;
    end
  end

  always_comb begin
    for (int i = 0; i < 6; i++) cfg_flat[32*i +: 32] = cfg_q[i];
  end

  rcpc_front #(.FracBits(FRAC_BITS)) u_front (
    .clk_i, .rst_ni, .cfg_i(cfg_flat),
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_data_i({s_axis_tlast, s_axis_tuser, s_axis_tdata}),
    .push_o(push), .plane_o(qin), .full_i(full)
  );

  rcpc_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(qin), .full_o(full),
    .pop_i(pop), .empty_o(empty), .data_o(qout)
  );

  rcpc_back #(.FracBits(FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .near_start_i(cfg_q[rcpc_pkg::REG_NEAR]), .far_start_i(cfg_q[rcpc_pkg::REG_FAR]),
    .empty_i(empty), .plane_i(qout), .pop_o(pop),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_data_o(res)
  );

  assign m_axis_tdata = {6'd0, res[65:0]};
  assign m_axis_tlast = res[66];
endmodule
`default_nettype wire

>>> hw/rtl/rcpc_checker.sv
// Port-level checker for ray_convex_plane_clip, bound to the top level.
// Depends on ray_convex_plane_clip_assert.svh.
`default_nettype none
`include "ray_convex_plane_clip_assert.svh"
module rcpc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [71:0] m_axis_tdata,
  input wire logic        pready
);
  `RCPC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `RCPC_ASSERT_IMP(a_pad_zero, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[71:66] == 6'd0)
  `RCPC_ASSERT_IMP(a_pready, clk_i, rst_ni, 1'b1, pready)
  `RCPC_ASSERT_NEXT(a_in_busy, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)
endmodule
bind ray_convex_plane_clip rcpc_checker u_rcpc_checker (.*);
`default_nettype wire

>>> dv/rcpc_checker.sv
// Checker for the ray convex plane clip block: watches the plane and result
// channels, computes expected bounds per plane and compares. Uses rcpc_pkg.
`timescale 1ns / 1ps
module rcpc_tb_checker #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,
  input  logic         s_axis_tuser,
  input  logic         s_axis_tlast,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [71:0]  m_axis_tdata,
  input  logic         m_axis_tlast,
  output int           fail_count,
  output int           pending
);
  typedef struct packed {
    logic        live;
    logic [31:0] near_v;
    logic [31:0] far_v;
    logic        entered;
    logic        last;
  } bound_t;

  logic signed [31:0] ray_reg [8];
  logic signed [63:0] near_b, far_b;
  logic entered_b, live_b;
  bound_t bounds_q [$];

  assign pending = bounds_q.size();

  // exact three-term dot product, floor-shifted by FRAC_BITS
  function automatic logic signed [127:0] dot_fx(input int base,
                                                  input logic [95:0] nrm);
    logic signed [127:0] acc;
    acc = 0;
    for (int i = 0; i < 3; i++)
      acc += 128'(ray_reg[base+i]) * 128'($signed(nrm[32*i +: 32]));
    return acc >>> FRAC_BITS;
  endfunction

  // (num << FRAC_BITS) / den toward zero, saturated to 32 bits
  function automatic logic signed [63:0] cross_dist(input logic signed [127:0] num,
                                                    input logic signed [127:0] den);
    logic signed [191:0] q;
    q = (192'(num) <<< FRAC_BITS) / 192'(den);
    if (q > 192'sh7fffffff) return 64'sh7fffffff;
    if (q < -192'sh80000000) return -64'sh80000000;
    return 64'(q);
  endfunction

  task automatic clip_plane(input logic [127:0] d, input logic first, input logic last);
    logic signed [127:0] a, p, off;
    logic signed [63:0] t;
    logic front;
    bound_t b;
    off = 128'($signed(d[127:96]));
    if (first) begin
      near_b = ray_reg[rcpc_pkg::REG_NEAR]; far_b = ray_reg[rcpc_pkg::REG_FAR];
      entered_b = 0; live_b = 1;
    end
    if (live_b) begin
      a = dot_fx(rcpc_pkg::REG_DIR_X, d[95:0]);
      p = dot_fx(rcpc_pkg::REG_START_X, d[95:0]);
      front = p > off;
      if (a == 0) begin
        if (front) live_b = 0;
      end else begin
        t = cross_dist(off - p, a);
        if (front && t < 0) live_b = 0;
        else if (front || t < 0) begin
          if (near_b < t) begin near_b = t; entered_b = 1; end
        end else if (t < far_b) far_b = t;
      end
    end
    b.live = live_b; b.near_v = near_b[31:0]; b.far_v = far_b[31:0];
    b.entered = entered_b; b.last = last;
    bounds_q.push_back(b);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bound_t e;
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) ray_reg[i] <= 0;
      ray_reg[rcpc_pkg::REG_NEAR] <= 32'h80000000;
      ray_reg[rcpc_pkg::REG_FAR] <= 32'h7fffffff;
      near_b = 0; far_b = 0; entered_b = 0; live_b = 1;
      fail_count <= 0;
      bounds_q.delete();
    end else begin
      if (psel && penable && pwrite) ray_reg[paddr[4:2]] <= pwdata;
      if (s_axis_tvalid && s_axis_tready)
        clip_plane(s_axis_tdata, s_axis_tuser, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (bounds_q.size() == 0) begin
          $display("%t unexpected result word %h", $time, m_axis_tdata);
          fail_count <= fail_count + 1;
        end else begin
          e = bounds_q.pop_front();
          if ({m_axis_tdata[65:0], m_axis_tlast} !==
              {e.entered, e.far_v, e.near_v, e.live, e.last}) begin
            $display("%t mismatch exp live=%b near=%h far=%h ent=%b last=%b",
                     $time, e.live, e.near_v, e.far_v, e.entered, e.last);
            $display("%t          act live=%b near=%h far=%h ent=%b last=%b",
                     $time, m_axis_tdata[0], m_axis_tdata[32:1], m_axis_tdata[64:33],
                     m_axis_tdata[65], m_axis_tlast);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

>>> dv/tb.sv
// Testbench top for ray_convex_plane_clip: clock, reset, APB register setup,
// plane stimulus with random idling, verdict. Uses rcpc_pkg and rcpc_tb_checker.
`timescale 1ns / 1ps
module tb;
  localparam int LIMIT = 3_000_000;
  localparam int DRAIN = 400;

  logic clk_i = 0, rst_ni = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [4:0] paddr = 0;
  logic [31:0] pwdata = 0, prdata;
  logic pready;
  logic s_axis_tvalid = 0, s_axis_tready, s_axis_tuser = 0, s_axis_tlast = 0;
  logic [127:0] s_axis_tdata = 0;
  logic m_axis_tvalid, m_axis_tready = 0, m_axis_tlast;
  logic [71:0] m_axis_tdata;
  int fail_count, pending;
  int cycles = 0;
  bit hold_sink = 0;  // long receiver hold-off requested
  bit calm = 0;       // last part: no idling

  ray_convex_plane_clip dut (.*);
  rcpc_tb_checker chk (.*);

  initial forever #5 clk_i = ~clk_i;

  // timeout watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: random stall bursts, or a long counted hold-off
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (hold_sink) begin
        m_axis_tready <= 0;
        for (n = 0; n < 600; n++) @(posedge clk_i);
        hold_sink = 0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1;
        @(posedge clk_i);
      end
    end
  end

  // setup, access, then idle
  task automatic reg_write(input rcpc_pkg::reg_idx_e idx, input logic [31:0] v);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk_i);
  endtask

  // drop valid, drain, then let the block settle before touching registers
  task automatic wait_idle();
    s_axis_tvalid <= 0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  // leaves valid high on return; the next call reloads it or briefly drops it, wait_idle drops it
  task automatic send_plane(input logic [31:0] nx, ny, nz, off,
                            input logic first, last);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {off, nz, ny, nx};
    s_axis_tuser <= first;
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // mostly small-magnitude values so that crossings land in range
  function automatic logic [31:0] rnd_val();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 3) == 0 ? 32'h80000000 : 32'h7fffffff;
      2: return 0;
      default: return $signed($urandom_range(0, 32'h000a0000)) - 32'sh00050000;
    endcase
  endfunction

  task automatic load_ray(input bit extreme);
    rcpc_pkg::reg_idx_e r;
    for (int i = 0; i < 8; i++) begin
      r = rcpc_pkg::reg_idx_e'(i);
      if (extreme) reg_write(r, (i % 2) ? 32'h7fffffff : 32'h80000000);
      else reg_write(r, rnd_val());
    end
    if (!extreme && $urandom_range(0, 1)) begin
      reg_write(rcpc_pkg::REG_NEAR, 32'h80000000);
      reg_write(rcpc_pkg::REG_FAR, 32'h7fffffff);
    end
  endtask

  // one solid: 1..6 planes, first and last marked unless broken (then random)
  task automatic send_solid(input bit broken, output int np);
    np = $urandom_range(1, 6);
    for (int i = 0; i < np; i++)
      send_plane(rnd_val(), rnd_val(), rnd_val(), rnd_val(),
                 broken ? 1'($urandom_range(0, 1)) : (i == 0),
                 broken ? 1'($urandom_range(0, 1)) : (i == np - 1));
  endtask

  initial begin
    int sent;
    int np;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: ray from the origin along unit +x against hand-placed planes
    reg_write(rcpc_pkg::REG_DIR_X, 32'h00010000);
    reg_write(rcpc_pkg::REG_START_X, 32'h00000000);
    send_plane(32'h00010000, 0, 0, 32'h00020000, 1, 0);  // crossing, behind
    send_plane(32'hffff0000, 0, 0, 32'h00010000, 0, 0);  // crossing, entry raise
    send_plane(0, 32'h00010000, 0, 32'h00010000, 0, 0);  // parallel, behind
    send_plane(0, 32'h00010000, 0, 32'hffff0000, 0, 1);  // parallel, in front
    send_plane(32'h00010000, 0, 0, 32'h00010000, 0, 0);  // miss held
    send_plane(32'h00010000, 0, 0, 32'hfffe0000, 1, 0);  // in front, t < 0
    send_plane(32'hffff0000, 0, 0, 32'h00030000, 1, 1);  // behind, t < 0
    send_plane(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 1, 1);
    send_plane(32'h00000001, 0, 0, 32'h7fffffff, 1, 1);  // divide saturates
    send_plane(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'h80000000, 0, 0);
    send_plane(0, 0, 0, 0, 1, 1);
    sent = 11;
    wait_idle();
    load_ray(1);
    send_plane(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 1, 1);
    send_plane(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 1, 0);
    sent += 2;

    // fill the block while the receiver holds off
    wait_idle();
    hold_sink = 1;
    for (int i = 0; i < 6; i++) send_plane(rnd_val(), rnd_val(), rnd_val(), rnd_val(), 1, 1);
    sent += 6;

    // random phases; each new ray only after a full drain
    while (sent < 950) begin
      wait_idle();
      if (sent > 850) calm = 1;
      load_ray($urandom_range(0, 9) == 0);
      for (int s = 0; s < 8 && sent < 950; s++) begin
        send_solid($urandom_range(0, 7) == 0, np);
        sent += np;
      end
    end

    wait_idle();
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/rcpc_pkg.sv
hw/rtl/rcpc_front.sv
hw/rtl/rcpc_queue.sv
hw/rtl/rcpc_back.sv
hw/rtl/ray_convex_plane_clip.sv
hw/rtl/rcpc_checker.sv
dv/rcpc_checker.sv
dv/tb.sv
